// ===== src/sbc_pkg.sv =====
// Package for the syllable bigram counter: codes, constants and the types
// that pass between the front end, the queue and the back end. No dependencies.
package sbc_pkg;

  localparam int SYMBOL_CODES_DEF = 94;
  localparam int COUNT_WIDTH_DEF  = 32;
  localparam int CODE_W           = 7;
  localparam int IDX_W            = 14;
  localparam int QUEUE_DEPTH      = 2;
  localparam logic [7:0] CODE_BASE = 8'hA1;

  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_COUNTED   = 2'd0,
    ST_COUNT_REJ = 2'd1,
    ST_QUERY_OK  = 2'd2,
    ST_QUERY_REJ = 2'd3
  } sbc_status_e;

  typedef struct packed {
    sbc_status_e      kind;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } sbc_cmd_t;

  typedef struct packed {
    sbc_status_e status;
    logic [7:0]  follower_lead;
    logic [7:0]  follower_trail;
    logic [31:0] best_count;
    logic        meets_min;
  } sbc_res_t;

endpackage

// ===== src/sbc_in_if.sv =====
// Input request channel of the bigram counter.
// Plain valid/ready handshake; no dependencies.
interface sbc_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] first_lead;
  logic [7:0] first_trail;
  logic [7:0] second_lead;
  logic [7:0] second_trail;

  modport source (output valid, opcode, first_lead, first_trail, second_lead,
                  second_trail, input ready);
  modport sink (input valid, opcode, first_lead, first_trail, second_lead,
                second_trail, output ready);
endinterface

// ===== src/sbc_out_if.sv =====
// Result channel of the bigram counter.
// Plain valid/ready handshake; no dependencies.
interface sbc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  follower_lead;
  logic [7:0]  follower_trail;
  logic [31:0] best_count;
  logic        meets_min;

  modport source (output valid, status, follower_lead, follower_trail, best_count,
                  meets_min, input ready);
  modport sink (input valid, status, follower_lead, follower_trail, best_count,
                meets_min, output ready);
endinterface

// ===== src/sbc_cfg_if.sv =====
// Configuration write channel of the bigram counter (min_count only).
// Plain valid/ready handshake; no dependencies.
interface sbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== src/syllable_bigram_count_argmax.sv =====
// Top level of the syllable bigram counter with argmax query.
// Depends on sbc_pkg, the channel interfaces, sbc_front, sbc_queue, sbc_back.
//
// Keeps one saturating counter per ordered pair of syllables in a counter
// memory with one read and one write port, with one mark bit per first
// syllable. After reset a clearing pass writes all SYMBOL_CODES^2 marks
// while no request is taken; min_count writes are taken at any time. A
// count first clears its row (row clear) the first time that row is used
// since reset. A query on a used row scans the row through the memory read
// port, one entry per cycle; a query on an unused row skips the scan. A
// two-entry queue lets requests be taken while the back end works or a
// result waits.
module syllable_bigram_count_argmax #(
  parameter int SYMBOL_CODES = sbc_pkg::SYMBOL_CODES_DEF,
  parameter int COUNT_WIDTH  = sbc_pkg::COUNT_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbc_in_if.sink     in_i,
  sbc_cfg_if.sink    cfg_i,
  sbc_out_if.source  out_o
);

  logic [31:0] min_count_q;
  logic        init_done, q_full, f_valid, head_valid, head_pop;
  sbc_pkg::sbc_cmd_t f_cmd, head_cmd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_count_q <= 32'd1;
    end else if (cfg_i.valid) begin
      min_count_q <= cfg_i.data;
    end
  end

  sbc_front #(.SYMBOL_CODES(SYMBOL_CODES)) u_front (
    .in_i        (in_i),
    .init_done_i (init_done),
    .ready_i     (!q_full),
    .valid_o     (f_valid),
    .cmd_o       (f_cmd)
  );

  sbc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid && !q_full),
    .data_i  (f_cmd),
    .full_o  (q_full),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .data_o  (head_cmd)
  );

  sbc_back #(.SYMBOL_CODES(SYMBOL_CODES), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_cmd),
    .head_pop_o   (head_pop),
    .min_count_i  (min_count_q),
    .init_done_o  (init_done),
    .out_o        (out_o)
  );

endmodule

// ===== src/sbc_front.sv =====
// Front end: checks the byte ranges of a request and turns it into a
// row/column command. Depends on sbc_pkg and sbc_in_if.
module sbc_front #(
  parameter int SYMBOL_CODES = sbc_pkg::SYMBOL_CODES_DEF
) (
  sbc_in_if.sink           in_i,
  input  logic             init_done_i,
  input  logic             ready_i,
  output logic             valid_o,
  output sbc_pkg::sbc_cmd_t cmd_o
);

  logic [7:0] off_fl, off_ft, off_sl, off_st;
  logic       ok_fl, ok_ft, ok_sl, ok_st;
  logic [sbc_pkg::CODE_W-1:0] c_fl, c_ft, c_sl, c_st;

  assign off_fl = in_i.first_lead   - sbc_pkg::CODE_BASE;
  assign off_ft = in_i.first_trail  - sbc_pkg::CODE_BASE;
  assign off_sl = in_i.second_lead  - sbc_pkg::CODE_BASE;
  assign off_st = in_i.second_trail - sbc_pkg::CODE_BASE;

  assign ok_fl = (in_i.first_lead   >= sbc_pkg::CODE_BASE) && (off_fl < 8'(SYMBOL_CODES));
  assign ok_ft = (in_i.first_trail  >= sbc_pkg::CODE_BASE) && (off_ft < 8'(SYMBOL_CODES));
  assign ok_sl = (in_i.second_lead  >= sbc_pkg::CODE_BASE) && (off_sl < 8'(SYMBOL_CODES));
  assign ok_st = (in_i.second_trail >= sbc_pkg::CODE_BASE) && (off_st < 8'(SYMBOL_CODES));

  assign c_fl = off_fl[sbc_pkg::CODE_W-1:0];
  assign c_ft = off_ft[sbc_pkg::CODE_W-1:0];
  assign c_sl = off_sl[sbc_pkg::CODE_W-1:0];
  assign c_st = off_st[sbc_pkg::CODE_W-1:0];

  always_comb begin
    cmd_o.row = sbc_pkg::IDX_W'(c_fl * SYMBOL_CODES + c_ft);
    cmd_o.col = sbc_pkg::IDX_W'(c_sl * SYMBOL_CODES + c_st);
    if (in_i.opcode == sbc_pkg::OP_QUERY) begin
      cmd_o.kind = (ok_fl && ok_ft) ? sbc_pkg::ST_QUERY_OK : sbc_pkg::ST_QUERY_REJ;
    end else begin
      cmd_o.kind = (ok_fl && ok_ft && ok_sl && ok_st) ? sbc_pkg::ST_COUNTED
                                                      : sbc_pkg::ST_COUNT_REJ;
    end
  end

  // hold off requests until the row marks have been cleared
  assign in_i.ready = ready_i && init_done_i;
  assign valid_o    = in_i.valid && init_done_i;

endmodule

// ===== src/sbc_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on sbc_pkg.
module sbc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sbc_pkg::sbc_cmd_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output sbc_pkg::sbc_cmd_t data_o
);

  localparam int PW = $clog2(sbc_pkg::QUEUE_DEPTH);

  sbc_pkg::sbc_cmd_t entry_q [sbc_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(sbc_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = entry_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_q] <= data_i;
  end

endmodule

// ===== src/sbc_back.sv =====
// Back end: counter memory, per-row marks, row clear, read-modify-write and
// the argmax row scan, with the result register. Depends on sbc_pkg, sbc_out_if.
module sbc_back #(
  parameter int SYMBOL_CODES = sbc_pkg::SYMBOL_CODES_DEF,
  parameter int COUNT_WIDTH  = sbc_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  sbc_pkg::sbc_cmd_t head_i,
  output logic              head_pop_o,
  input  logic [31:0]       min_count_i,
  output logic              init_done_o,
  sbc_out_if.source         out_o
);

  localparam int RS = SYMBOL_CODES * SYMBOL_CODES;
  localparam int RW = (RS > 1) ? $clog2(RS) : 1;
  localparam int AW = (RS * RS > 1) ? $clog2(RS * RS) : 1;
  localparam logic [sbc_pkg::IDX_W-1:0]  LAST      = sbc_pkg::IDX_W'(RS - 1);
  localparam logic [sbc_pkg::CODE_W-1:0] CODE_LAST = sbc_pkg::CODE_W'(SYMBOL_CODES - 1);
  localparam logic [COUNT_WIDTH-1:0]     CNT_MAX   = '1;

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_MARK = 4'd2;
  localparam logic [3:0] S_MCHK = 4'd3;
  localparam logic [3:0] S_CLR  = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_WR   = 4'd6;
  localparam logic [3:0] S_SCAN = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state_q;
  sbc_pkg::sbc_cmd_t cmd_q;
  sbc_pkg::sbc_res_t res_q;
  logic [AW-1:0] base_q;
  logic [sbc_pkg::IDX_W-1:0] ptr_q;
  logic [sbc_pkg::CODE_W-1:0] sl_q, st_q, dl_q, dt_q, bl_q, bt_q;
  logic issue_done_q, dv_q, dlast_q;
  logic [COUNT_WIDTH-1:0] best_q, rd_q;
  logic mark_q;

  logic [COUNT_WIDTH-1:0] cnt_mem [RS * RS];
  logic                   mark_mem [RS];

  logic [AW-1:0] rd_addr, wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic mem_we, mark_we, mark_wdata;
  logic [sbc_pkg::IDX_W-1:0] mark_waddr;
  logic head_rej, found;

  assign rd_addr = base_q + AW'((state_q == S_SCAN) ? ptr_q : cmd_q.col);
  assign head_rej = (head_i.kind == sbc_pkg::ST_COUNT_REJ) ||
                    (head_i.kind == sbc_pkg::ST_QUERY_REJ);
  assign found = (best_q != '0);

  always_comb begin
    mem_we     = 1'b0;
    wr_addr    = base_q + AW'(ptr_q);
    wr_data    = '0;
    mark_we    = 1'b0;
    mark_waddr = ptr_q;
    mark_wdata = 1'b0;
    case (state_q)
      S_INIT: mark_we = 1'b1;
      S_CLR: begin
        mem_we = 1'b1;
        if (ptr_q == LAST) begin
          mark_we    = 1'b1;
          mark_waddr = cmd_q.row;
          mark_wdata = 1'b1;
        end
      end
      S_WR: begin
        mem_we  = 1'b1;
        wr_addr = base_q + AW'(cmd_q.col);
        wr_data = (rd_q == CNT_MAX) ? rd_q : rd_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) cnt_mem[wr_addr] <= wr_data;
    rd_q <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) mark_mem[mark_waddr[RW-1:0]] <= mark_wdata;
    mark_q <= mark_mem[cmd_q.row[RW-1:0]];
  end

  assign head_pop_o  = (state_q == S_IDLE) && head_valid_i;
  assign init_done_o = (state_q != S_INIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      cmd_q        <= '0;
      res_q        <= '0;
      base_q       <= '0;
      ptr_q        <= '0;
      sl_q         <= '0;
      st_q         <= '0;
      dl_q         <= '0;
      dt_q         <= '0;
      bl_q         <= '0;
      bt_q         <= '0;
      issue_done_q <= 1'b0;
      dv_q         <= 1'b0;
      dlast_q      <= 1'b0;
      best_q       <= '0;
    end else begin
      dv_q <= 1'b0;
      case (state_q)
        S_INIT: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q == LAST) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (head_valid_i) begin
            cmd_q  <= head_i;
            base_q <= AW'(head_i.row * RS);
            if (head_rej) begin
              res_q        <= '0;
              res_q.status <= head_i.kind;
              state_q      <= S_OUT;
            end else begin
              state_q <= S_MARK;
            end
          end
        end
        S_MARK: state_q <= S_MCHK;
        S_MCHK: begin
          ptr_q        <= '0;
          sl_q         <= '0;
          st_q         <= '0;
          issue_done_q <= 1'b0;
          best_q       <= '0;
          bl_q         <= '0;
          bt_q         <= '0;
          if (cmd_q.kind == sbc_pkg::ST_COUNTED) begin
            state_q <= mark_q ? S_RD : S_CLR;
          end else if (mark_q) begin
            state_q <= S_SCAN;
          end else begin
            // untouched row since reset reads as all zero
            res_q           <= '0;
            res_q.status    <= sbc_pkg::ST_QUERY_OK;
            res_q.meets_min <= (min_count_i == '0);
            state_q         <= S_OUT;
          end
        end
        S_CLR: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q == LAST) state_q <= S_RD;
        end
        S_RD: state_q <= S_WR;
        S_WR: begin
          res_q        <= '0;
          res_q.status <= sbc_pkg::ST_COUNTED;
          state_q      <= S_OUT;
        end
        S_SCAN: begin
          if (!issue_done_q) begin
            dv_q    <= 1'b1;
            dl_q    <= sl_q;
            dt_q    <= st_q;
            dlast_q <= (ptr_q == LAST);
            ptr_q   <= ptr_q + 1'b1;
            if (st_q == CODE_LAST) begin
              st_q <= '0;
              sl_q <= sl_q + 1'b1;
            end else begin
              st_q <= st_q + 1'b1;
            end
            if (ptr_q == LAST) issue_done_q <= 1'b1;
          end
          if (dv_q) begin
            // strict compare keeps the lowest code on a tie
            if (rd_q > best_q) begin
              best_q <= rd_q;
              bl_q   <= dl_q;
              bt_q   <= dt_q;
            end
            if (dlast_q) state_q <= S_FIN;
          end
        end
        S_FIN: begin
          res_q.status         <= sbc_pkg::ST_QUERY_OK;
          res_q.follower_lead  <= found ? sbc_pkg::CODE_BASE + 8'(bl_q) : 8'd0;
          res_q.follower_trail <= found ? sbc_pkg::CODE_BASE + 8'(bt_q) : 8'd0;
          res_q.best_count     <= 32'(best_q);
          res_q.meets_min      <= (32'(best_q) >= min_count_i);
          state_q              <= S_OUT;
        end
        S_OUT: begin
          if (out_o.ready) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid          = (state_q == S_OUT);
  assign out_o.status         = res_q.status;
  assign out_o.follower_lead  = res_q.follower_lead;
  assign out_o.follower_trail = res_q.follower_trail;
  assign out_o.best_count     = res_q.best_count;
  assign out_o.meets_min      = res_q.meets_min;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) && !out_o.ready |=> (state_q == S_OUT) && $stable(res_q))
    else $error("result changed while stalled");

  a_mem_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLR) || (state_q == S_WR))
    else $error("counter write outside clear or update");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop_o |=> (state_q != S_IDLE) && (state_q != S_INIT))
    else $error("pop did not start work");

endmodule

// ===== tb/sv/syllable_bigram_count_argmax_test.sv =====
// Self-checking testbench for syllable_bigram_count_argmax: counts and argmax queries.
// Depends on sbc_pkg, the three channel interfaces and the block's top level.
module syllable_bigram_count_argmax_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ROW_LEN  = sbc_pkg::SYMBOL_CODES_DEF * sbc_pkg::SYMBOL_CODES_DEF;
  localparam logic [7:0]  CODE_TOP = sbc_pkg::CODE_BASE + 8'(sbc_pkg::SYMBOL_CODES_DEF - 1);

  logic clk;
  logic rst_n;

  sbc_in_if  in_if ();
  sbc_cfg_if cfg_if ();
  sbc_out_if out_if ();

  syllable_bigram_count_argmax dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  // Predictor state: sparse pair counters keyed by row * ROW_LEN + column.
  int unsigned       pair_tally[int];
  logic [31:0]       min_count_q;
  sbc_pkg::sbc_res_t pending_results[$];

  int  fail_count;
  bit  idle_en;
  int  hold_cycles;
  int  stall_left;
  logic [7:0] busy_rows[4][2];
  logic [7:0] followers[6][2];

  initial begin
    clk = 1'b0;
  end
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h, want %0h", what, got, want);
    fail_count++;
  endtask

  function automatic bit byte_ok(input logic [7:0] b);
    return (b >= sbc_pkg::CODE_BASE) && (b <= CODE_TOP);
  endfunction

  function automatic int code_of(input logic [7:0] b);
    return int'(b - sbc_pkg::CODE_BASE);
  endfunction

  // Work out the result of one request and update the counter table.
  function automatic sbc_pkg::sbc_res_t bigram_outcome(input logic op,
                                                       input logic [7:0] fl,
                                                       input logic [7:0] ft,
                                                       input logic [7:0] sl,
                                                       input logic [7:0] st);
    sbc_pkg::sbc_res_t r;
    int          row;
    int          key;
    int unsigned best;
    int          best_key;
    r = '0;
    row = code_of(fl) * sbc_pkg::SYMBOL_CODES_DEF + code_of(ft);
    if (op == sbc_pkg::OP_COUNT) begin
      if (!(byte_ok(fl) && byte_ok(ft) && byte_ok(sl) && byte_ok(st))) begin
        r.status = sbc_pkg::ST_COUNT_REJ;
      end else begin
        r.status = sbc_pkg::ST_COUNTED;
        key = row * ROW_LEN + code_of(sl) * sbc_pkg::SYMBOL_CODES_DEF + code_of(st);
        if (!pair_tally.exists(key)) pair_tally[key] = 0;
        if (pair_tally[key] != 32'hFFFF_FFFF) pair_tally[key]++;
      end
    end else if (!(byte_ok(fl) && byte_ok(ft))) begin
      r.status = sbc_pkg::ST_QUERY_REJ;
    end else begin
      r.status = sbc_pkg::ST_QUERY_OK;
      best = 0;
      best_key = -1;
      // Keys come in ascending order, so a strict compare keeps the lowest code on ties.
      foreach (pair_tally[k]) begin
        if (k / ROW_LEN == row && pair_tally[k] > best) begin
          best = pair_tally[k];
          best_key = k % ROW_LEN;
        end
      end
      if (best_key >= 0) begin
        r.follower_lead  = sbc_pkg::CODE_BASE + 8'(best_key / sbc_pkg::SYMBOL_CODES_DEF);
        r.follower_trail = sbc_pkg::CODE_BASE + 8'(best_key % sbc_pkg::SYMBOL_CODES_DEF);
      end
      r.best_count = best;
      r.meets_min  = (best >= min_count_q);
    end
    return r;
  endfunction

  task automatic send_request(input logic op, input logic [7:0] fl, input logic [7:0] ft,
                              input logic [7:0] sl, input logic [7:0] st);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.opcode       <= op;
    in_if.first_lead   <= fl;
    in_if.first_trail  <= ft;
    in_if.second_lead  <= sl;
    in_if.second_trail <= st;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_results.push_back(bigram_outcome(op, fl, ft, sl, st));
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_min_count(input logic [31:0] value);
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    min_count_q = value;
    @(posedge clk);
  endtask

  function automatic logic [7:0] bad_byte();
    case ($urandom_range(0, 2))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 8'hA0));
    endcase
  endfunction

  function automatic logic [7:0] good_byte();
    return 8'($urandom_range(sbc_pkg::CODE_BASE, CODE_TOP));
  endfunction

  task automatic test_rejects_and_empty();
    send_request(sbc_pkg::OP_QUERY, 8'hA1, 8'hA1, 8'h00, 8'hFF);
    send_request(sbc_pkg::OP_QUERY, 8'hFF, 8'hA1, 8'hA1, 8'hA1);
    send_request(sbc_pkg::OP_QUERY, 8'hA1, 8'hA0, 8'hA1, 8'hA1);
    send_request(sbc_pkg::OP_COUNT, 8'h00, 8'hA1, 8'hA1, 8'hA1);
    send_request(sbc_pkg::OP_COUNT, 8'hA1, 8'hFF, 8'hA1, 8'hA1);
    send_request(sbc_pkg::OP_COUNT, 8'hA1, 8'hA1, 8'hA0, 8'hA1);
    send_request(sbc_pkg::OP_COUNT, 8'hA1, 8'hA1, 8'hA1, 8'hFF);
    drain_results();
  endtask

  task automatic test_counts_and_ties();
    // Equal counts on two followers: the lower code must win.
    send_request(sbc_pkg::OP_COUNT, 8'hA1, 8'hA1, 8'hFE, 8'hFE);
    send_request(sbc_pkg::OP_COUNT, 8'hA1, 8'hA1, 8'hA1, 8'hA1);
    send_request(sbc_pkg::OP_COUNT, 8'hA1, 8'hA1, 8'hFE, 8'hFE);
    send_request(sbc_pkg::OP_COUNT, 8'hA1, 8'hA1, 8'hA1, 8'hA1);
    send_request(sbc_pkg::OP_QUERY, 8'hA1, 8'hA1, 8'h00, 8'h00);
    send_request(sbc_pkg::OP_COUNT, 8'hFE, 8'hFE, 8'hA1, 8'hA2);
    send_request(sbc_pkg::OP_COUNT, 8'hFE, 8'hFE, 8'hFE, 8'hA1);
    send_request(sbc_pkg::OP_COUNT, 8'hFE, 8'hFE, 8'hFE, 8'hA1);
    send_request(sbc_pkg::OP_QUERY, 8'hFE, 8'hFE, 8'hFF, 8'hFF);
    drain_results();
  endtask

  task automatic test_min_count();
    write_min_count(32'h0);
    send_request(sbc_pkg::OP_QUERY, 8'hB0, 8'hC0, 8'hA1, 8'hA1);
    send_request(sbc_pkg::OP_QUERY, 8'hA1, 8'hA1, 8'hA1, 8'hA1);
    write_min_count(32'hFFFF_FFFF);
    send_request(sbc_pkg::OP_QUERY, 8'hFE, 8'hFE, 8'hA1, 8'hA1);
    write_min_count(32'd2);
    send_request(sbc_pkg::OP_QUERY, 8'hA1, 8'hA1, 8'hA1, 8'hA1);
    send_request(sbc_pkg::OP_QUERY, 8'hFE, 8'hFE, 8'hA1, 8'hA1);
    write_min_count(32'd3);
    send_request(sbc_pkg::OP_QUERY, 8'hA1, 8'hA1, 8'hA1, 8'hA1);
    write_min_count(32'd1);
  endtask

  task automatic test_back_pressure();
    int i;
    hold_cycles = 300;
    for (i = 0; i < 20; i++) begin
      send_request(sbc_pkg::OP_COUNT, 8'hA1, 8'hA1, followers[i % 6][0],
                   followers[i % 6][1]);
    end
    drain_results();
  endtask

  task automatic test_random_traffic(input int n_items);
    int i;
    int pick;
    int r;
    int f;
    for (i = 0; i < n_items; i++) begin
      if (i % 250 == 249) begin
        case ($urandom_range(0, 3))
          0: write_min_count(32'h0);
          1: write_min_count(32'hFFFF_FFFF);
          default: write_min_count($urandom_range(1, 5));
        endcase
      end
      if (i == n_items - 200) idle_en = 1'b0;
      pick = $urandom_range(0, 99);
      r = $urandom_range(0, 3);
      f = $urandom_range(0, 5);
      if (pick < 60) begin
        send_request(sbc_pkg::OP_COUNT, busy_rows[r][0], busy_rows[r][1],
                     followers[f][0], followers[f][1]);
      end else if (pick < 68) begin
        send_request(sbc_pkg::OP_COUNT, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
      end else if (pick < 72) begin
        send_request(sbc_pkg::OP_COUNT, busy_rows[r][0], busy_rows[r][1], bad_byte(),
                     good_byte());
      end else if (pick < 93) begin
        send_request(sbc_pkg::OP_QUERY, good_byte(), good_byte(),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else if (pick < 96) begin
        send_request(sbc_pkg::OP_QUERY, busy_rows[r][0], busy_rows[r][1],
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else begin
        send_request(sbc_pkg::OP_QUERY, bad_byte(), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
    end
    drain_results();
  endtask

  // Result side: random stalls, plus a long hold-off when asked.
  initial begin
    out_if.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (idle_en && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 9);
      end
    end
  end

  always @(posedge clk) begin
    sbc_pkg::sbc_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(out_if.status), 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_if.status !== want.status)
          report_mismatch("status", 32'(out_if.status), 32'(want.status));
        if (out_if.follower_lead !== want.follower_lead)
          report_mismatch("follower_lead", 32'(out_if.follower_lead), 32'(want.follower_lead));
        if (out_if.follower_trail !== want.follower_trail)
          report_mismatch("follower_trail", 32'(out_if.follower_trail),
                          32'(want.follower_trail));
        if (out_if.best_count !== want.best_count)
          report_mismatch("best_count", out_if.best_count, want.best_count);
        if (out_if.meets_min !== want.meets_min)
          report_mismatch("meets_min", 32'(out_if.meets_min), 32'(want.meets_min));
      end
    end
  end

  initial begin
    #500ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int i;
    rst_n = 1'b0;
    in_if.valid        <= 1'b0;
    in_if.opcode       <= sbc_pkg::OP_COUNT;
    in_if.first_lead   <= 8'h0;
    in_if.first_trail  <= 8'h0;
    in_if.second_lead  <= 8'h0;
    in_if.second_trail <= 8'h0;
    cfg_if.valid       <= 1'b0;
    cfg_if.data        <= 32'h0;
    fail_count  = 0;
    idle_en     = 1'b1;
    hold_cycles = 0;
    min_count_q = 32'd1;
    busy_rows[0] = '{8'hA1, 8'hA1};
    busy_rows[1] = '{8'hFE, 8'hFE};
    busy_rows[2] = '{good_byte(), good_byte()};
    busy_rows[3] = '{good_byte(), good_byte()};
    followers[0] = '{8'hA1, 8'hA1};
    followers[1] = '{8'hFE, 8'hFE};
    for (i = 2; i < 6; i++) followers[i] = '{good_byte(), good_byte()};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_rejects_and_empty();
    test_counts_and_ties();
    test_min_count();
    test_back_pressure();
    test_random_traffic(1250);

    // Hold the sender off until every result is back, then wind down.
    drain_results();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
